/* rtl/dq2x2_pkg.sv */
// Package for the 2x2 block transform quantizer: widths, stage words,
// the quantizer threshold bank and helper functions. No dependencies.
package dq2x2_pkg;

    localparam int FRAC_BITS  = 15;
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 6;
    localparam int TABLE_LEN  = 63;
    localparam int TABLE_MID  = 31;
    localparam int NUM_THR    = TABLE_LEN - 1;
    localparam int AVG_SCALE  = 63;
    localparam int SUM_W      = PIX_W + 3;
    localparam int CSUM_W     = PIX_W + 2;
    localparam int PROD_W     = SUM_W + 6;
    localparam int CMP_W      = (FRAC_BITS + 3 > SUM_W + 1) ? FRAC_BITS + 3 : SUM_W + 1;

    typedef logic signed [CMP_W-1:0] t_cmp;
    typedef t_cmp t_thr_arr [NUM_THR];

    localparam int QUANT_MILLI [TABLE_LEN] = '{
        -300, -280, -250, -230, -200, -180, -160, -150, -130, -120, -110, -100,
        -95, -88, -82, -77, -72, -66, -60, -55, -50, -44, -39, -33, -28, -22,
        -18, -11, -8, -5, -2, 0, 2, 5, 8, 11, 18, 22, 28, 33, 39, 44, 50, 55,
        60, 66, 72, 77, 82, 88, 95, 100, 110, 120, 130, 150, 160, 180, 200, 230,
        250, 280, 300
    };

    function automatic longint quant_entry(int i);
        longint m;
        longint mag;
        longint q;
        m   = longint'(QUANT_MILLI[i]);
        mag = (m < 0) ? -m : m;
        q   = (mag * (longint'(1) << FRAC_BITS) + 500) / 1000;
        return (m < 0) ? -q : q;
    endfunction

    // midpoint j between entries j and j+1, scaled to match twice a 4x coefficient
    function automatic t_thr_arr quant_thresholds();
        t_thr_arr t;
        for (int j = 0; j < NUM_THR; j++) begin
            t[j] = t_cmp'(4 * (quant_entry(j) + quant_entry(j + 1)));
        end
        return t;
    endfunction

    localparam t_thr_arr QUANT_THR = quant_thresholds();

    // thermometer to binary: encode the single 1-to-0 transition position
    function automatic logic signed [COEF_W-1:0] therm_index(input logic [NUM_THR-1:0] t);
        logic [NUM_THR+1:0] ext;
        logic [COEF_W-1:0]  cnt;
        ext = {1'b0, t, 1'b1};
        cnt = '0;
        for (int c = 0; c <= NUM_THR; c++) begin
            if (ext[c] && !ext[c + 1]) begin
                cnt = cnt | COEF_W'(c);
            end
        end
        return $signed(cnt - COEF_W'(TABLE_MID));
    endfunction

    typedef struct packed {
        logic        [SUM_W-1:0]  sa;
        logic signed [SUM_W-1:0]  sb;
        logic signed [SUM_W-1:0]  sc;
        logic signed [SUM_W-1:0]  sd;
        logic signed [CSUM_W-1:0] pb_sum;
        logic signed [CSUM_W-1:0] pr_sum;
    } t_s1;

    typedef struct packed {
        logic        [PROD_W-1:0]  avg_prod;
        logic        [NUM_THR-1:0] thr_b;
        logic        [NUM_THR-1:0] thr_c;
        logic        [NUM_THR-1:0] thr_d;
        logic signed [CSUM_W-1:0]  pb_sum;
        logic signed [CSUM_W-1:0]  pr_sum;
    } t_s2;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

/* rtl/dq2x2_if.sv */
// Stream interfaces for the 2x2 block transform quantizer: pixel block in,
// coefficient word out. Depends on dq2x2_pkg.
interface dq2x2_blk_if;
    logic                                  valid;
    logic                                  ready;
    logic        [dq2x2_pkg::PIX_W-1:0]    y_top_left;
    logic        [dq2x2_pkg::PIX_W-1:0]    y_top_right;
    logic        [dq2x2_pkg::PIX_W-1:0]    y_bottom_left;
    logic        [dq2x2_pkg::PIX_W-1:0]    y_bottom_right;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pb_top_left;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pb_top_right;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pb_bottom_left;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pb_bottom_right;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pr_top_left;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pr_top_right;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pr_bottom_left;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pr_bottom_right;

    modport source (
        output valid, y_top_left, y_top_right, y_bottom_left, y_bottom_right,
               pb_top_left, pb_top_right, pb_bottom_left, pb_bottom_right,
               pr_top_left, pr_top_right, pr_bottom_left, pr_bottom_right,
        input  ready
    );
    modport sink (
        input  valid, y_top_left, y_top_right, y_bottom_left, y_bottom_right,
               pb_top_left, pb_top_right, pb_bottom_left, pb_bottom_right,
               pr_top_left, pr_top_right, pr_bottom_left, pr_bottom_right,
        output ready
    );
endinterface

interface dq2x2_res_if;
    logic                                  valid;
    logic                                  ready;
    logic        [dq2x2_pkg::COEF_W-1:0]   coef_avg;
    logic signed [dq2x2_pkg::COEF_W-1:0]   coef_vertical;
    logic signed [dq2x2_pkg::COEF_W-1:0]   coef_horizontal;
    logic signed [dq2x2_pkg::COEF_W-1:0]   coef_diagonal;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pb_mean;
    logic signed [dq2x2_pkg::PIX_W-1:0]    pr_mean;

    modport source (
        output valid, coef_avg, coef_vertical, coef_horizontal, coef_diagonal,
               pb_mean, pr_mean,
        input  ready
    );
    modport sink (
        input  valid, coef_avg, coef_vertical, coef_horizontal, coef_diagonal,
               pb_mean, pr_mean,
        output ready
    );
endinterface

/* rtl/dq2x2_sum_stage.sv */
// First pipeline stage: Haar sums of the four lumas and chroma sums.
// Depends on dq2x2_pkg and dq2x2_blk_if.
module dq2x2_sum_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dq2x2_blk_if.sink         i_blk,
    output dq2x2_pkg::t_s1    o_s1,
    output dq2x2_pkg::t_hs    o_hs_valid,
    input  dq2x2_pkg::t_hs    i_hs_ready
);
    logic                         r_valid;
    dq2x2_pkg::t_s1               r_s1;
    dq2x2_pkg::t_s1               n_s1;
    logic                         load;
    logic signed [dq2x2_pkg::SUM_W-1:0] y1, y2, y3, y4;

    assign i_blk.ready = !r_valid || i_hs_ready.ready;
    assign load        = i_blk.valid && i_blk.ready;

    always_comb begin
        y1 = $signed({3'b000, i_blk.y_top_left});
        y2 = $signed({3'b000, i_blk.y_top_right});
        y3 = $signed({3'b000, i_blk.y_bottom_left});
        y4 = $signed({3'b000, i_blk.y_bottom_right});
        n_s1.sa     = $unsigned(y4 + y3 + y2 + y1);
        n_s1.sb     = y4 + y3 - y2 - y1;
        n_s1.sc     = y4 - y3 + y2 - y1;
        n_s1.sd     = y4 - y3 - y2 + y1;
        n_s1.pb_sum = dq2x2_pkg::CSUM_W'(i_blk.pb_top_left)
                    + dq2x2_pkg::CSUM_W'(i_blk.pb_top_right)
                    + dq2x2_pkg::CSUM_W'(i_blk.pb_bottom_left)
                    + dq2x2_pkg::CSUM_W'(i_blk.pb_bottom_right);
        n_s1.pr_sum = dq2x2_pkg::CSUM_W'(i_blk.pr_top_left)
                    + dq2x2_pkg::CSUM_W'(i_blk.pr_top_right)
                    + dq2x2_pkg::CSUM_W'(i_blk.pr_bottom_left)
                    + dq2x2_pkg::CSUM_W'(i_blk.pr_bottom_right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_blk.ready) begin
            r_valid <= i_blk.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1             = r_s1;
    assign o_hs_valid.valid = r_valid;
    assign o_hs_valid.ready = i_blk.ready;
endmodule

/* rtl/dq2x2_cmp_stage.sv */
// Second pipeline stage: threshold comparator bank for the three detail
// coefficients and the scaling product of the average. Depends on dq2x2_pkg.
module dq2x2_cmp_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dq2x2_pkg::t_s1    i_s1,
    input  dq2x2_pkg::t_hs    i_hs_valid,
    output dq2x2_pkg::t_hs    o_hs_ready,
    output dq2x2_pkg::t_s2    o_s2,
    output dq2x2_pkg::t_hs    o_hs_valid,
    input  dq2x2_pkg::t_hs    i_hs_ready
);
    logic                   r_valid;
    dq2x2_pkg::t_s2         r_s2;
    dq2x2_pkg::t_s2         n_s2;
    logic                   adv;
    dq2x2_pkg::t_cmp        xb, xc, xd;

    assign adv = !r_valid || i_hs_ready.ready;

    always_comb begin
        xb = dq2x2_pkg::t_cmp'(i_s1.sb) <<< 1;
        xc = dq2x2_pkg::t_cmp'(i_s1.sc) <<< 1;
        xd = dq2x2_pkg::t_cmp'(i_s1.sd) <<< 1;
        for (int j = 0; j < dq2x2_pkg::NUM_THR; j++) begin
            n_s2.thr_b[j] = xb > dq2x2_pkg::QUANT_THR[j];
            n_s2.thr_c[j] = xc > dq2x2_pkg::QUANT_THR[j];
            n_s2.thr_d[j] = xd > dq2x2_pkg::QUANT_THR[j];
        end
        n_s2.avg_prod = dq2x2_pkg::PROD_W'(i_s1.sa)
                      * dq2x2_pkg::PROD_W'(dq2x2_pkg::AVG_SCALE);
        n_s2.pb_sum   = i_s1.pb_sum;
        n_s2.pr_sum   = i_s1.pr_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_hs_valid.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_hs_valid.valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2             = r_s2;
    assign o_hs_valid.valid = r_valid;
    assign o_hs_valid.ready = adv;
    assign o_hs_ready.valid = r_valid;
    assign o_hs_ready.ready = adv;
endmodule

/* rtl/dq2x2_out_stage.sv */
// Third pipeline stage and output register: table index from the comparator
// thermometer, average saturation, chroma mean. Depends on dq2x2_pkg, dq2x2_res_if.
module dq2x2_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dq2x2_pkg::t_s2    i_s2,
    input  dq2x2_pkg::t_hs    i_hs_valid,
    output dq2x2_pkg::t_hs    o_hs_ready,
    dq2x2_res_if.source       o_res
);
    logic                                     r_valid;
    logic        [dq2x2_pkg::COEF_W-1:0]      r_avg,  n_avg;
    logic signed [dq2x2_pkg::COEF_W-1:0]      r_vert, n_vert;
    logic signed [dq2x2_pkg::COEF_W-1:0]      r_horz, n_horz;
    logic signed [dq2x2_pkg::COEF_W-1:0]      r_diag, n_diag;
    logic signed [dq2x2_pkg::PIX_W-1:0]       r_pb,   n_pb;
    logic signed [dq2x2_pkg::PIX_W-1:0]       r_pr,   n_pr;
    logic        [dq2x2_pkg::PROD_W-1:0]      avg_q;
    logic signed [dq2x2_pkg::CSUM_W-1:0]      pb_adj, pr_adj;
    logic                                     adv;

    assign adv = !r_valid || o_res.ready;

    always_comb begin
        avg_q  = i_s2.avg_prod >> (dq2x2_pkg::FRAC_BITS + 2);
        n_avg  = (avg_q > dq2x2_pkg::PROD_W'(dq2x2_pkg::AVG_SCALE))
               ? dq2x2_pkg::COEF_W'(dq2x2_pkg::AVG_SCALE)
               : avg_q[dq2x2_pkg::COEF_W-1:0];
        n_vert = dq2x2_pkg::therm_index(i_s2.thr_b);
        n_horz = dq2x2_pkg::therm_index(i_s2.thr_c);
        n_diag = dq2x2_pkg::therm_index(i_s2.thr_d);
        pb_adj = i_s2.pb_sum + (i_s2.pb_sum[dq2x2_pkg::CSUM_W-1]
               ? dq2x2_pkg::CSUM_W'(3) : dq2x2_pkg::CSUM_W'(0));
        pr_adj = i_s2.pr_sum + (i_s2.pr_sum[dq2x2_pkg::CSUM_W-1]
               ? dq2x2_pkg::CSUM_W'(3) : dq2x2_pkg::CSUM_W'(0));
        n_pb   = pb_adj[dq2x2_pkg::CSUM_W-1:2];
        n_pr   = pr_adj[dq2x2_pkg::CSUM_W-1:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_hs_valid.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_hs_valid.valid) begin
            r_avg  <= n_avg;
            r_vert <= n_vert;
            r_horz <= n_horz;
            r_diag <= n_diag;
            r_pb   <= n_pb;
            r_pr   <= n_pr;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.coef_avg        = r_avg;
    assign o_res.coef_vertical   = r_vert;
    assign o_res.coef_horizontal = r_horz;
    assign o_res.coef_diagonal   = r_diag;
    assign o_res.pb_mean         = r_pb;
    assign o_res.pr_mean         = r_pr;
    assign o_hs_ready.valid      = r_valid;
    assign o_hs_ready.ready      = adv;
endmodule

/* rtl/block_dct_quantize_2x2_top.sv */
// 2x2 block transform quantizer, top level: sum, compare and output stages.
// Depends on dq2x2_pkg, dq2x2_if, dq2x2_sum_stage, dq2x2_cmp_stage, dq2x2_out_stage.
//
// Accepts one 2x2 pixel block per clock while the output is not stalled, and
// delivers its coefficient word through three register stages: luma and chroma sums,
// a bank of 62 midpoint comparators per detail coefficient alongside the x63 scaling
// multiply, and the thermometer-to-index count with average saturation and chroma
// mean in the output register. Each stage holds its word while the next one is
// full, so a stall at the output backs up without loss and empty stages fill in.
module block_dct_quantize_2x2_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dq2x2_blk_if.sink     i_blk,
    dq2x2_res_if.source   o_res
);
    dq2x2_pkg::t_s1 s1;
    dq2x2_pkg::t_s2 s2;
    dq2x2_pkg::t_hs hs1_v, hs1_r, hs2_v, hs2_r;

    dq2x2_sum_stage u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_blk      (i_blk),
        .o_s1       (s1),
        .o_hs_valid (hs1_v),
        .i_hs_ready (hs1_r)
    );

    dq2x2_cmp_stage u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1       (s1),
        .i_hs_valid (hs1_v),
        .o_hs_ready (hs1_r),
        .o_s2       (s2),
        .o_hs_valid (hs2_v),
        .i_hs_ready (hs2_r)
    );

    dq2x2_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s2       (s2),
        .i_hs_valid (hs2_v),
        .o_hs_ready (hs2_r),
        .o_res      (o_res)
    );

    a_flow_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_blk.valid && i_blk.ready) ##1 o_res.ready ##1 o_res.ready |=> o_res.valid)
        else $error("accepted word not delivered after three free-flowing cycles");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_blk.ready)
        else $error("input stalled while output register is empty");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.coef_vertical != -6'sd32)
                     && (o_res.coef_horizontal != -6'sd32)
                     && (o_res.coef_diagonal != -6'sd32))
        else $error("table index out of range");
endmodule

/* tb/tb_block_dct_quantize_2x2_top.sv */
// Self-checking bench for block_dct_quantize_2x2_top: a clocked driver streams 2x2 blocks,
// a clocked monitor checks each coefficient word against a local predictor.
// Depends on dq2x2_pkg, dq2x2_if and the block's RTL.
module tb_block_dct_quantize_2x2_top;
    import dq2x2_pkg::*;

    localparam int DRAIN_AT    = 400;
    localparam int CALM_LO     = 700;
    localparam int CALM_HI     = 1000;
    localparam int IDLE_PCT    = 17;
    localparam int RANDOM_BLKS = 1650;

    localparam int LEVEL_MILLI [TABLE_LEN] = '{
        -300, -280, -250, -230, -200, -180, -160, -150, -130, -120, -110, -100,
        -95, -88, -82, -77, -72, -66, -60, -55, -50, -44, -39, -33, -28, -22,
        -18, -11, -8, -5, -2, 0, 2, 5, 8, 11, 18, 22, 28, 33, 39, 44, 50, 55,
        60, 66, 72, 77, 82, 88, 95, 100, 110, 120, 130, 150, 160, 180, 200, 230,
        250, 280, 300
    };

    localparam logic [PIX_W-1:0] CORNER_VALS [5] = '{
        16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff
    };

    typedef struct packed {
        logic [3:0][PIX_W-1:0] y;
        logic [3:0][PIX_W-1:0] pb;
        logic [3:0][PIX_W-1:0] pr;
    } t_blk;

    typedef struct packed {
        logic        [COEF_W-1:0] avg;
        logic signed [COEF_W-1:0] vert;
        logic signed [COEF_W-1:0] horz;
        logic signed [COEF_W-1:0] diag;
        logic signed [PIX_W-1:0]  pb_mean;
        logic signed [PIX_W-1:0]  pr_mean;
    } t_coefs;

    logic i_clk;
    logic i_rst_n;

    dq2x2_blk_if blk_if ();
    dq2x2_res_if res_if ();

    block_dct_quantize_2x2_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk_if),
        .o_res   (res_if)
    );

    t_blk   pending_blks [$];
    t_coefs coef_expected [$];
    t_blk   cur_blk;
    int     n_sent;
    int     n_acc;
    int     n_got;
    int     total_blks;
    int     mismatches;
    int     unexpected;
    logic   drain_done;

    function automatic longint level_q15(int i);
        longint m;
        longint mag;
        longint q;
        m   = longint'(LEVEL_MILLI[i]);
        mag = (m < 0) ? -m : m;
        q   = (mag * (longint'(1) << FRAC_BITS) + 500) / 1000;
        return (m < 0) ? -q : q;
    endfunction

    // nearest level, lowest index on equal distance
    function automatic logic signed [COEF_W-1:0] detail_index(longint x4);
        longint lo_lim;
        longint hi_lim;
        longint d;
        longint best_d;
        int     best_i;
        lo_lim = 4 * level_q15(0);
        hi_lim = 4 * level_q15(TABLE_LEN - 1);
        if (x4 > hi_lim) x4 = hi_lim;
        if (x4 < lo_lim) x4 = lo_lim;
        best_d = -1;
        best_i = 0;
        for (int i = 0; i < TABLE_LEN; i++) begin
            d = x4 - 4 * level_q15(i);
            if (d < 0) d = -d;
            if (best_d < 0 || d < best_d) begin
                best_d = d;
                best_i = i;
            end
        end
        return COEF_W'(best_i - TABLE_MID);
    endfunction

    function automatic logic signed [PIX_W-1:0] chroma_avg(logic [3:0][PIX_W-1:0] p);
        longint s;
        s = 0;
        for (int i = 0; i < 4; i++) s += longint'($signed(p[i]));
        return PIX_W'(s / 4);
    endfunction

    function automatic t_coefs predict_coefs(t_blk b);
        t_coefs r;
        longint y [4];
        longint avg;
        for (int i = 0; i < 4; i++) y[i] = longint'(b.y[i]);
        avg = ((y[0] + y[1] + y[2] + y[3]) * AVG_SCALE) / (4 * (longint'(1) << FRAC_BITS));
        if (avg > AVG_SCALE) avg = AVG_SCALE;
        r.avg     = COEF_W'(avg);
        r.vert    = detail_index(y[3] + y[2] - y[1] - y[0]);
        r.horz    = detail_index(y[3] - y[2] + y[1] - y[0]);
        r.diag    = detail_index(y[3] - y[2] - y[1] + y[0]);
        r.pb_mean = chroma_avg(b.pb);
        r.pr_mean = chroma_avg(b.pr);
        return r;
    endfunction

    function automatic t_blk luma_blk(int tl, int tr, int bl, int br);
        t_blk b;
        b      = '0;
        b.y[0] = PIX_W'(tl);
        b.y[1] = PIX_W'(tr);
        b.y[2] = PIX_W'(bl);
        b.y[3] = PIX_W'(br);
        return b;
    endfunction

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin : drive_blocks
        logic hold;
        logic idle;
        if (!i_rst_n) begin
            blk_if.valid <= 1'b0;
            n_acc        <= 0;
            drain_done   <= 1'b0;
        end else begin
            if (blk_if.valid && blk_if.ready) begin
                coef_expected.push_back(predict_coefs(cur_blk));
                n_acc <= n_acc + 1;
            end
            if (n_sent == DRAIN_AT && !blk_if.valid && n_got == n_acc) drain_done <= 1'b1;
            hold = (n_sent == DRAIN_AT) && !drain_done;
            idle = !(n_sent >= CALM_LO && n_sent < CALM_HI) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
            if (!blk_if.valid || blk_if.ready) begin
                if (pending_blks.size() == 0 || hold || idle) begin
                    blk_if.valid <= 1'b0;
                end else begin
                    cur_blk                = pending_blks.pop_front();
                    n_sent                 = n_sent + 1;
                    blk_if.y_top_left      <= cur_blk.y[0];
                    blk_if.y_top_right     <= cur_blk.y[1];
                    blk_if.y_bottom_left   <= cur_blk.y[2];
                    blk_if.y_bottom_right  <= cur_blk.y[3];
                    blk_if.pb_top_left     <= cur_blk.pb[0];
                    blk_if.pb_top_right    <= cur_blk.pb[1];
                    blk_if.pb_bottom_left  <= cur_blk.pb[2];
                    blk_if.pb_bottom_right <= cur_blk.pb[3];
                    blk_if.pr_top_left     <= cur_blk.pr[0];
                    blk_if.pr_top_right    <= cur_blk.pr[1];
                    blk_if.pr_bottom_left  <= cur_blk.pr[2];
                    blk_if.pr_bottom_right <= cur_blk.pr[3];
                    blk_if.valid           <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_coefs
        t_coefs got;
        t_coefs want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            n_got        <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.avg     = res_if.coef_avg;
                got.vert    = res_if.coef_vertical;
                got.horz    = res_if.coef_horizontal;
                got.diag    = res_if.coef_diagonal;
                got.pb_mean = res_if.pb_mean;
                got.pr_mean = res_if.pr_mean;
                if (n_got >= n_acc) begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display("unexpected coefficient word: avg=%0d v=%0d h=%0d d=%0d",
                                 got.avg, got.vert, got.horz, got.diag);
                end else begin
                    want = coef_expected[n_got];
                    if (got.avg !== want.avg || got.vert !== want.vert ||
                        got.horz !== want.horz || got.diag !== want.diag ||
                        got.pb_mean !== want.pb_mean || got.pr_mean !== want.pr_mean) begin
                        mismatches++;
                        if (mismatches + unexpected <= 10) begin
                            $display("word %0d expected avg=%0d v=%0d h=%0d d=%0d pb=%0d pr=%0d",
                                     n_got, want.avg, want.vert, want.horz, want.diag,
                                     want.pb_mean, want.pr_mean);
                            $display("word %0d actual   avg=%0d v=%0d h=%0d d=%0d pb=%0d pr=%0d",
                                     n_got, got.avg, got.vert, got.horz, got.diag,
                                     got.pb_mean, got.pr_mean);
                        end
                    end
                    n_got <= n_got + 1;
                end
            end
            if (n_got >= CALM_LO && n_got < CALM_HI)
                res_if.ready <= 1'b1;
            else
                res_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        #3_000_000;
        $display("block_dct_quantize_2x2_top test failed");
        $finish;
    end

    initial begin : stimulus
        t_blk   b;
        longint t;
        int     ks [3];
        int     k;
        int     mag;
        int     base;
        int     spread;
        int     pick;
        int     v;
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        n_sent     = 0;
        mismatches = 0;
        unexpected = 0;
        blk_if.valid = 1'b0;
        {blk_if.y_top_left, blk_if.y_top_right, blk_if.y_bottom_left, blk_if.y_bottom_right} = '0;
        {blk_if.pb_top_left, blk_if.pb_top_right, blk_if.pb_bottom_left,
         blk_if.pb_bottom_right} = '0;
        {blk_if.pr_top_left, blk_if.pr_top_right, blk_if.pr_bottom_left,
         blk_if.pr_bottom_right} = '0;
        res_if.ready = 1'b0;

        // range extremes, saturation, clamp and chroma truncation
        pending_blks.push_back(luma_blk(0, 0, 0, 0));
        b = luma_blk(32768, 32768, 32768, 32768);
        b.pb = {4{16'sd16384}};
        b.pr = {4{-16'sd16384}};
        pending_blks.push_back(b);
        b = luma_blk(65535, 65535, 65535, 65535);
        b.pb = {4{16'h8000}};
        b.pr = {4{16'h7fff}};
        pending_blks.push_back(b);
        b = luma_blk(0, 0, 0, 65535);
        b.pb = {4{16'h7fff}};
        b.pr = {4{16'h8000}};
        pending_blks.push_back(b);
        b = luma_blk(65535, 0, 0, 0);
        b.pb = {16'sd0, 16'sd0, 16'sd0, -16'sd1};
        b.pr = {16'sd0, 16'sd0, -16'sd2, -16'sd3};
        pending_blks.push_back(b);
        b = luma_blk(0, 0, 0, int'(4 * level_q15(TABLE_LEN - 1)));
        b.pb = {16'sd0, 16'sd0, 16'sd2, 16'sd3};
        pending_blks.push_back(b);
        pending_blks.push_back(luma_blk(0, 0, 0, int'(4 * level_q15(TABLE_LEN - 1)) + 1));
        pending_blks.push_back(luma_blk(int'(4 * level_q15(TABLE_LEN - 1)) + 1, 0, 0, 0));

        // exact level hits
        ks = '{32, 45, 61};
        foreach (ks[i]) begin
            pending_blks.push_back(luma_blk(0, 0, 0, int'(4 * level_q15(ks[i]))));
            pending_blks.push_back(luma_blk(0, int'(4 * level_q15(ks[i])), 0, 0));
        end

        // halfway between neighbors, and just past halfway
        ks = '{31, 48, 60};
        foreach (ks[i]) begin
            v = int'(2 * (level_q15(ks[i]) + level_q15(ks[i] + 1)));
            pending_blks.push_back(luma_blk(0, 0, 0, v));
            pending_blks.push_back(luma_blk(v, 0, 0, 0));
            pending_blks.push_back(luma_blk(0, 0, 0, v + 1));
        end

        for (int n = 0; n < RANDOM_BLKS; n++) begin
            pick = $urandom_range(0, 99);
            b = '0;
            for (int i = 0; i < 4; i++) begin
                b.pb[i] = PIX_W'(int'($urandom_range(0, 32768)) - 16384);
                b.pr[i] = PIX_W'(int'($urandom_range(0, 32768)) - 16384);
            end
            if (pick < 35) begin
                for (int i = 0; i < 4; i++) b.y[i] = PIX_W'($urandom_range(0, 32768));
            end else if (pick < 55) begin
                base = $urandom_range(0, 32768);
                case ($urandom_range(0, 3))
                    0: spread = 8;
                    1: spread = 64;
                    2: spread = 512;
                    default: spread = 4096;
                endcase
                for (int i = 0; i < 4; i++) begin
                    v = base + int'($urandom_range(0, 2 * spread)) - spread;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                    b.y[i] = PIX_W'(v);
                end
            end else if (pick < 75) begin
                // land on or near a level or a midpoint; a common offset leaves details intact
                k = $urandom_range(0, TABLE_LEN - 1);
                if ($urandom_range(0, 1) == 0 || k == TABLE_LEN - 1)
                    t = 4 * level_q15(k);
                else
                    t = 2 * (level_q15(k) + level_q15(k + 1));
                t = t + int'($urandom_range(0, 4)) - 2;
                mag  = (t < 0) ? int'(-t) : int'(t);
                base = $urandom_range(0, 65535 - mag);
                for (int i = 0; i < 4; i++) b.y[i] = PIX_W'(base);
                k = $urandom_range(0, 3);
                b.y[k] = PIX_W'(base + mag);
            end else if (pick < 90) begin
                b.y  = {$urandom(), $urandom()};
                b.pb = {$urandom(), $urandom()};
                b.pr = {$urandom(), $urandom()};
            end else begin
                for (int i = 0; i < 4; i++) begin
                    b.y[i]  = CORNER_VALS[$urandom_range(0, 4)];
                    b.pb[i] = CORNER_VALS[$urandom_range(0, 4)];
                    b.pr[i] = CORNER_VALS[$urandom_range(0, 4)];
                end
            end
            pending_blks.push_back(b);
        end
        total_blks = pending_blks.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_acc == total_blks);
        wait (n_got == n_acc);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d blocks: directed extremes, level hits and ties, then random blocks",
                 total_blks);
        $display("with idle and stall gaps and one full drain; %0d mismatched, %0d unexpected",
                 mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0) begin
            $display("block_dct_quantize_2x2_top test passed");
        end else begin
            $display("block_dct_quantize_2x2_top test failed");
        end
        $finish;
    end

endmodule
